>>> design/adv2d_pkg.sv
// ----------------------------------------------------------------------------
// adv2d_pkg
// Shared types and constants for the 2-D central-difference advection core:
// transaction payloads of both channels and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package adv2d_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 31;
	localparam int SIZE_W      = 11;
	localparam int SCALE_W     = 31;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_STEP_SCALE  = 2'd2;

	// reset values of the registers
	localparam logic [SIZE_W-1:0]  GRID_WIDTH_RST  = 11'd1024;
	localparam logic [SIZE_W-1:0]  GRID_HEIGHT_RST = 11'd1024;
	localparam logic [SCALE_W-1:0] STEP_SCALE_RST  = 31'd65536;

	// payload widths
	localparam int VAL_W   = 32;
	localparam int COORD_W = 10;

	// input transaction: both velocity components of one grid point
	typedef struct packed {
		logic signed [VAL_W-1:0] u_value;
		logic signed [VAL_W-1:0] v_value;
	} in_item_t;

	// output transaction: advection terms of one interior point
	typedef struct packed {
		logic [COORD_W-1:0]      center_x;
		logic [COORD_W-1:0]      center_y;
		logic signed [VAL_W-1:0] adv_u;
		logic signed [VAL_W-1:0] adv_v;
	} out_item_t;

endpackage

`default_nettype wire

>>> design/advection_stencil_2d_core.sv
// ----------------------------------------------------------------------------
// advection_stencil_2d_core
// Streaming central-difference advection stencil over a raster-order grid.
// Two line-buffer memories (u and v) hold two rows each, banked by row
// parity; a three-wide window of the middle row sits in registers. Each
// interior point yields scale*(v*(f_down-f_up) + u*(f_right-f_left)) for
// f = u and f = v, floored to Q16.16 and saturated to 32 bits.
//
//   channel  | signals                          | transaction when
//   ---------+----------------------------------+------------------------------
//   input    | in_valid, in_ready, in_item      | in_valid & in_ready at clk
//   output   | out_valid, out_ready, out_item   | out_valid & out_ready at clk
//   config   | cfg_wen, cfg_index, cfg_data     | cfg_wen at clk
//
// One point is taken per cycle while in_ready is high; the result of center
// (x, y-1) follows point (x, y) through stages 1 to 5 into the output register.
// Line buffers are written and read in the cycle a point is taken, so the
// memory ports set the rate and no two points touch the same entry in flight.
// A stall at the output backs up through the six stages to in_ready.
// Reset clears positions, window and valids; memories need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module advection_stencil_2d_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire adv2d_pkg::in_item_t                  in_item,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output adv2d_pkg::out_item_t                      out_item,
	input  wire logic                                 cfg_wen,
	input  wire logic [adv2d_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [adv2d_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// position and address widths
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int AW   = CW + 1;
	localparam int MEMD = 2 ** AW;
	localparam int LWW  = $clog2(MAX_WIDTH + 1);
	localparam int LWH  = $clog2(MAX_HEIGHT + 1);
	localparam int LWM  = (LWW > LWH) ? LWW : LWH;
	localparam int XW   = ((LWM > adv2d_pkg::SIZE_W) ? LWM : adv2d_pkg::SIZE_W) + 1;

	// arithmetic widths
	localparam int VW   = adv2d_pkg::VAL_W;
	localparam int DW   = VW + 1;
	localparam int PW   = VW + DW;
	localparam int TW   = PW - FRAC_BITS;
	localparam int SW   = TW + 1;
	localparam int LO_W = 25;
	localparam int HI_W = SW - LO_W;
	localparam int KW   = adv2d_pkg::SCALE_W + 1;
	localparam int PLW  = KW + LO_W + 1;
	localparam int PHW  = KW + HI_W;
	localparam int FW   = KW + HI_W + LO_W + 1;

	// configuration registers
	logic [adv2d_pkg::SIZE_W-1:0]  grid_width_q;
	logic [adv2d_pkg::SIZE_W-1:0]  grid_height_q;
	logic [adv2d_pkg::SCALE_W-1:0] step_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= adv2d_pkg::GRID_WIDTH_RST;
			grid_height_q <= adv2d_pkg::GRID_HEIGHT_RST;
			step_scale_q  <= adv2d_pkg::STEP_SCALE_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				adv2d_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data[adv2d_pkg::SIZE_W-1:0];
				adv2d_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data[adv2d_pkg::SIZE_W-1:0];
				adv2d_pkg::CFG_STEP_SCALE:  step_scale_q  <= cfg_data[adv2d_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// stage handshake: a stage frees when empty or when it moves on
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic free_s1, free_s2, free_s3, free_s4, free_s5, free_s6;
	logic acc;
	logic emit_s2;

	assign free_s6  = !valid_s6 || out_ready;
	assign free_s5  = !valid_s5 || free_s6;
	assign free_s4  = !valid_s4 || free_s5;
	assign free_s3  = !valid_s3 || free_s4;
	assign free_s2  = !valid_s2 || free_s3;
	assign free_s1  = !valid_s1 || free_s2;
	assign in_ready = free_s1;
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (free_s1) valid_s1 <= acc;
			if (free_s2) valid_s2 <= valid_s1;
			if (free_s3) valid_s3 <= valid_s2 && emit_s2;
			if (free_s4) valid_s4 <= valid_s3;
			if (free_s5) valid_s5 <= valid_s4;
			if (free_s6) valid_s6 <= valid_s5;
		end
	end

	// raster position
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// stage 0: size clamp, position normalize, line buffer addresses
	logic [XW-1:0] w_eff, h_eff, col_x, row_x, col_nx, row_nx;
	logic [AW-1:0] addr_wr, addr_a, addr_b;
	logic          emit_s0, col0_s0, next_ok_s0;

	always_comb begin
		logic [XW-1:0] gw, gh, c0, r0, c1, r1;
		gw = XW'(grid_width_q);
		gh = XW'(grid_height_q);
		if (gw < XW'(3))               w_eff = XW'(3);
		else if (gw > XW'(MAX_WIDTH))  w_eff = XW'(MAX_WIDTH);
		else                           w_eff = gw;
		if (gh < XW'(3))               h_eff = XW'(3);
		else if (gh > XW'(MAX_HEIGHT)) h_eff = XW'(MAX_HEIGHT);
		else                           h_eff = gh;

		c0 = XW'(col_q);
		r0 = XW'(row_q);
		if (c0 >= w_eff) begin
			c0 = '0;
			r0 = r0 + XW'(1);
		end
		if (r0 >= h_eff) r0 = '0;
		col_x = c0;
		row_x = r0;

		c1 = c0 + XW'(1);
		r1 = r0;
		next_ok_s0 = c1 < w_eff;
		if (!next_ok_s0) begin
			c1 = '0;
			r1 = r0 + XW'(1);
			if (r1 >= h_eff) r1 = '0;
		end
		col_nx = c1;
		row_nx = r1;

		col0_s0 = c0 == '0;
		emit_s0 = (r0 >= XW'(2)) && !col0_s0 && (c0 + XW'(2) <= w_eff);

		// port a: the entry above, or the first middle-row entry at a row start
		addr_wr = {r0[0], c0[CW-1:0]};
		addr_a  = col0_s0 ? {~r0[0], {CW{1'b0}}} : {r0[0], c0[CW-1:0]};
		addr_b  = {~r0[0], c0[CW-1:0] + CW'(1)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			col_q <= col_nx[CW-1:0];
			row_q <= row_nx[RW-1:0];
		end
	end

	// line buffer memories: write and both reads in the transaction cycle
	logic signed [VW-1:0] u_mem [MEMD];
	logic signed [VW-1:0] v_mem [MEMD];
	logic signed [VW-1:0] u_rd_a_s1, u_rd_b_s1, v_rd_a_s1, v_rd_b_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			u_rd_a_s1      <= u_mem[addr_a];
			u_rd_b_s1      <= u_mem[addr_b];
			v_rd_a_s1      <= v_mem[addr_a];
			v_rd_b_s1      <= v_mem[addr_b];
			u_mem[addr_wr] <= in_item.u_value;
			v_mem[addr_wr] <= in_item.v_value;
		end
	end

	// stage 1 payload
	logic                         col0_s1, next_ok_s1, emit_s1;
	logic [adv2d_pkg::COORD_W-1:0] cx_s1, cy_s1;
	logic signed [VW-1:0]         u_in_s1, v_in_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			col0_s1    <= col0_s0;
			next_ok_s1 <= next_ok_s0;
			emit_s1    <= emit_s0;
			cx_s1      <= col_x[adv2d_pkg::COORD_W-1:0];
			cy_s1      <= row_x[adv2d_pkg::COORD_W-1:0] - adv2d_pkg::COORD_W'(1);
			u_in_s1    <= in_item.u_value;
			v_in_s1    <= in_item.v_value;
		end
	end

	// middle-row window shift
	logic signed [VW-1:0] u_left_q, u_mid_q, u_right_q;
	logic signed [VW-1:0] v_left_q, v_mid_q, v_right_q;
	logic signed [VW-1:0] u_left_n, u_mid_n, u_right_n;
	logic signed [VW-1:0] v_left_n, v_mid_n, v_right_n;
	logic                 ld_s2;

	assign ld_s2 = valid_s1 && free_s2;

	always_comb begin
		u_right_n = next_ok_s1 ? u_rd_b_s1 : '0;
		v_right_n = next_ok_s1 ? v_rd_b_s1 : '0;
		if (col0_s1) begin
			u_left_n = '0;
			v_left_n = '0;
			u_mid_n  = u_rd_a_s1;
			v_mid_n  = v_rd_a_s1;
		end else begin
			u_left_n = u_mid_q;
			v_left_n = v_mid_q;
			u_mid_n  = u_right_q;
			v_mid_n  = v_right_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_left_q  <= '0;
			u_mid_q   <= '0;
			u_right_q <= '0;
			v_left_q  <= '0;
			v_mid_q   <= '0;
			v_right_q <= '0;
		end else if (ld_s2) begin
			u_left_q  <= u_left_n;
			u_mid_q   <= u_mid_n;
			u_right_q <= u_right_n;
			v_left_q  <= v_left_n;
			v_mid_q   <= v_mid_n;
			v_right_q <= v_right_n;
		end
	end

	// stage 2: center values and differences
	logic signed [VW-1:0]          uc_s2, vc_s2;
	logic signed [DW-1:0]          du_vert_s2, du_horz_s2, dv_vert_s2, dv_horz_s2;
	logic [adv2d_pkg::COORD_W-1:0] cx_s2, cy_s2;

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			emit_s2    <= emit_s1;
			cx_s2      <= cx_s1;
			cy_s2      <= cy_s1;
			uc_s2      <= u_mid_n;
			vc_s2      <= v_mid_n;
			du_vert_s2 <= {u_in_s1[VW-1], u_in_s1} - {u_rd_a_s1[VW-1], u_rd_a_s1};
			dv_vert_s2 <= {v_in_s1[VW-1], v_in_s1} - {v_rd_a_s1[VW-1], v_rd_a_s1};
			du_horz_s2 <= {u_right_n[VW-1], u_right_n} - {u_left_n[VW-1], u_left_n};
			dv_horz_s2 <= {v_right_n[VW-1], v_right_n} - {v_left_n[VW-1], v_left_n};
		end
	end

	// stage 3: velocity times difference products
	logic signed [PW-1:0]          pu_vert_s3, pu_horz_s3, pv_vert_s3, pv_horz_s3;
	logic [adv2d_pkg::COORD_W-1:0] cx_s3, cy_s3;

	always_ff @(posedge clk) begin
		if (valid_s2 && emit_s2 && free_s3) begin
			cx_s3      <= cx_s2;
			cy_s3      <= cy_s2;
			pu_vert_s3 <= vc_s2 * du_vert_s2;
			pu_horz_s3 <= uc_s2 * du_horz_s2;
			pv_vert_s3 <= vc_s2 * dv_vert_s2;
			pv_horz_s3 <= uc_s2 * dv_horz_s2;
		end
	end

	// stage 4: floor each product to the fixed point and add
	logic signed [PW-1:0]          tu_vert, tu_horz, tv_vert, tv_horz;
	logic signed [SW-1:0]          sum_u_s4, sum_v_s4;
	logic [adv2d_pkg::COORD_W-1:0] cx_s4, cy_s4;

	assign tu_vert = pu_vert_s3 >>> FRAC_BITS;
	assign tu_horz = pu_horz_s3 >>> FRAC_BITS;
	assign tv_vert = pv_vert_s3 >>> FRAC_BITS;
	assign tv_horz = pv_horz_s3 >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (valid_s3 && free_s4) begin
			cx_s4    <= cx_s3;
			cy_s4    <= cy_s3;
			sum_u_s4 <= {tu_vert[TW-1], tu_vert[TW-1:0]} + {tu_horz[TW-1], tu_horz[TW-1:0]};
			sum_v_s4 <= {tv_vert[TW-1], tv_vert[TW-1:0]} + {tv_horz[TW-1], tv_horz[TW-1:0]};
		end
	end

	// stage 5: scale times sum, split into low and high partial products
	logic signed [KW-1:0]          scale_k;
	logic signed [HI_W-1:0]        su_hi, sv_hi;
	logic signed [LO_W:0]          su_lo, sv_lo;
	logic signed [PLW-1:0]         pu_lo_s5, pv_lo_s5;
	logic signed [PHW-1:0]         pu_hi_s5, pv_hi_s5;
	logic [adv2d_pkg::COORD_W-1:0] cx_s5, cy_s5;

	assign scale_k = {1'b0, step_scale_q};
	assign su_hi   = sum_u_s4[SW-1:LO_W];
	assign sv_hi   = sum_v_s4[SW-1:LO_W];
	assign su_lo   = {1'b0, sum_u_s4[LO_W-1:0]};
	assign sv_lo   = {1'b0, sum_v_s4[LO_W-1:0]};

	always_ff @(posedge clk) begin
		if (valid_s4 && free_s5) begin
			cx_s5    <= cx_s4;
			cy_s5    <= cy_s4;
			pu_lo_s5 <= scale_k * su_lo;
			pv_lo_s5 <= scale_k * sv_lo;
			pu_hi_s5 <= scale_k * su_hi;
			pv_hi_s5 <= scale_k * sv_hi;
		end
	end

	// stage 6: combine partials, floor, saturate into the output register
	logic signed [FW-1:0] full_u, full_v, q_u, q_v;
	logic signed [VW-1:0] sat_u, sat_v;

	always_comb begin
		full_u = (FW'(pu_hi_s5) <<< LO_W) + FW'(pu_lo_s5);
		full_v = (FW'(pv_hi_s5) <<< LO_W) + FW'(pv_lo_s5);
		q_u    = full_u >>> FRAC_BITS;
		q_v    = full_v >>> FRAC_BITS;
		if ((&q_u[FW-1:VW-1]) || !(|q_u[FW-1:VW-1])) sat_u = q_u[VW-1:0];
		else sat_u = q_u[FW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
		if ((&q_v[FW-1:VW-1]) || !(|q_v[FW-1:VW-1])) sat_v = q_v[VW-1:0];
		else sat_v = q_v[FW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		if (valid_s5 && free_s6) begin
			out_item.center_x <= cx_s5;
			out_item.center_y <= cy_s5;
			out_item.adv_u    <= sat_u;
			out_item.adv_v    <= sat_v;
		end
	end

	assign out_valid = valid_s6;

endmodule

`default_nettype wire
